// File: rtl/lsw_pkg.sv
// Package for the lap stopwatch: mode, command and sequencer codes.
// No dependencies; the top level, the checker and the testbench import it.
package lsw_pkg;

  // Watch mode as reported on the status channel.
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_PAUSED  = 2'd2,
    MODE_REVIEW  = 2'd3
  } mode_e;

  // Command codes; unused codes behave as a query.
  typedef enum logic [3:0] {
    OP_QUERY = 4'd0,
    OP_START = 4'd1,
    OP_PAUSE = 4'd2,
    OP_RESET = 4'd3,
    OP_LAP   = 4'd4,
    OP_ENTER = 4'd5,
    OP_EXIT  = 4'd6,
    OP_NEXT  = 4'd7,
    OP_PREV  = 4'd8
  } op_e;

  // Sequencer steps of one command.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_DIFF  = 3'd1,
    ST_SUM   = 3'd2,
    ST_APPLY = 3'd3,
    ST_READ  = 3'd4,
    ST_LOAD  = 3'd5
  } state_e;

  localparam int unsigned TimeW = 32;

endpackage

// File: rtl/lsw_if.sv
// Valid/ready channel interfaces for the lap stopwatch: command in, status out.
// Depends on nothing; widths of the lap counters follow the CNT_W parameter.
interface lsw_cmd_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [31:0] time_ms;

  modport source (output valid, output op, output time_ms, input ready);
  modport sink   (input valid, input op, input time_ms, output ready);
endinterface

interface lsw_stat_if #(
  parameter int unsigned CNT_W = 5
);
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [31:0]      watch_ms;
  logic [CNT_W-1:0] laps_stored;
  logic             lap_accepted;
  logic             view_valid;
  logic [CNT_W-1:0] view_lap_number;
  logic [31:0]      view_split_ms;
  logic [31:0]      view_lap_ms;

  modport source (output valid, output mode, output watch_ms, output laps_stored,
                  output lap_accepted, output view_valid, output view_lap_number,
                  output view_split_ms, output view_lap_ms, input ready);
  modport sink   (input valid, input mode, input watch_ms, input laps_stored,
                  input lap_accepted, input view_valid, input view_lap_number,
                  input view_split_ms, input view_lap_ms, output ready);
endinterface

// File: rtl/lsw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the lap store.
module lsw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/lap_stopwatch_with_review.sv
// Lap stopwatch with lap memory and review: top level.
// Depends on lsw_pkg, lsw_if (lsw_cmd_if, lsw_stat_if) and lsw_ram.
//
//  Channel  Dir  Word contents                                     Handshake
//  cmd_i    in   op, time_ms                                       valid/ready
//  stat_o   out  mode, watch_ms, laps_stored, lap_accepted,        valid/ready
//                view_valid, view_lap_number, view_split_ms,
//                view_lap_ms
//
// A command word passes through the steps accept, time minus start stamp, plus the
// accumulated time, apply (lap duration through the same adder, store write),
// store read at the cursor and the status load; one 32-bit adder does all sums.
// cmd_i is ready only in the idle step, so a new word is taken only after the last one's load.
// A stalled status word holds; the next command waits at the load step meanwhile.
// Reset clears mode, times, lap count and cursor; the lap store is never cleared.
module lap_stopwatch_with_review #(
  parameter int unsigned MAX_LAPS = 16,
  parameter int unsigned CNT_W    = $clog2(MAX_LAPS + 1)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsw_cmd_if.sink    cmd_i,
  lsw_stat_if.source stat_o
);
  import lsw_pkg::*;

  localparam int unsigned IdxW   = (MAX_LAPS > 1) ? $clog2(MAX_LAPS) : 1;
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_LAPS);
  localparam logic [CNT_W-1:0] OneCnt = CNT_W'(1);

  // Sequencer and watch state.
  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  mode_e            before_q, before_d;
  logic [TimeW-1:0] acc_q, acc_d;
  logic [TimeW-1:0] start_q, start_d;
  logic [TimeW-1:0] split_q, split_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic [IdxW-1:0]  cur_q, cur_d;
  logic             cvld_q, cvld_d;

  // Latched command and work registers.
  op_e              op_q;
  logic [TimeW-1:0] time_q;
  logic [TimeW-1:0] work_q;
  logic [TimeW-1:0] el_q, el_d;
  logic             lap_q, lap_ok;

  // Status output register.
  logic             out_vld_q;
  logic             load;

  // Shared adder/subtractor.
  logic [TimeW-1:0] alu_a, alu_b, alu_y;
  logic             alu_sub;

  // Lap store: split in the upper half, lap duration in the lower half.
  logic [2*TimeW-1:0] ram_rdata;
  logic               ram_rd_en;

  // Operand selection for the shared unit, one use per sequencer step.
  always_comb begin
    alu_a   = acc_q;
    alu_b   = work_q;
    alu_sub = 1'b0;
    case (state_q)
      ST_DIFF: begin
        alu_a   = time_q;
        alu_b   = start_q;
        alu_sub = 1'b1;
      end
      ST_SUM: begin
        alu_a   = acc_q;
        alu_b   = work_q;
        alu_sub = 1'b0;
      end
      ST_APPLY: begin
        alu_a   = work_q;
        alu_b   = split_q;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = acc_q;
        alu_b   = work_q;
        alu_sub = 1'b0;
      end
    endcase
    alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + TimeW'(alu_sub);
  end

  // Command decode: next watch state, using work_q as the running total.
  always_comb begin
    mode_d   = mode_q;
    before_d = before_q;
    acc_d    = acc_q;
    start_d  = start_q;
    split_d  = split_q;
    total_d  = total_q;
    cur_d    = cur_q;
    cvld_d   = cvld_q;
    lap_ok   = 1'b0;
    case (op_q)
      OP_START: begin
        if (mode_q == MODE_IDLE || mode_q == MODE_PAUSED) begin
          start_d = time_q;
          mode_d  = MODE_RUNNING;
        end
      end
      OP_PAUSE: begin
        if (mode_q == MODE_RUNNING) begin
          acc_d  = work_q;
          mode_d = MODE_PAUSED;
        end
      end
      OP_RESET: begin
        mode_d   = MODE_IDLE;
        before_d = MODE_IDLE;
        acc_d    = '0;
        start_d  = '0;
        split_d  = '0;
        total_d  = '0;
        cur_d    = '0;
        cvld_d   = 1'b0;
      end
      OP_LAP: begin
        if (mode_q == MODE_RUNNING && total_q < MaxCnt) begin
          lap_ok  = 1'b1;
          split_d = work_q;
          total_d = total_q + OneCnt;
        end
      end
      OP_ENTER: begin
        if (total_q != '0 && mode_q != MODE_REVIEW) begin
          before_d = mode_q;
          mode_d   = MODE_REVIEW;
          cur_d    = IdxW'(total_q - OneCnt);
          cvld_d   = 1'b1;
        end
      end
      OP_EXIT: begin
        if (mode_q == MODE_REVIEW) begin
          mode_d = before_q;
        end
      end
      OP_NEXT: begin
        if (mode_q == MODE_REVIEW && (CNT_W'(cur_q) + OneCnt) < total_q) begin
          cur_d = cur_q + IdxW'(1);
        end
      end
      OP_PREV: begin
        if (mode_q == MODE_REVIEW && cur_q != '0) begin
          cur_d = cur_q - IdxW'(1);
        end
      end
      default: begin
        mode_d = mode_q;
      end
    endcase

    // Elapsed time after the command; a fresh start shows the accumulated time.
    if (mode_d == MODE_RUNNING) begin
      el_d = (op_q == OP_START && mode_q != MODE_RUNNING) ? acc_q : work_q;
    end else begin
      el_d = acc_d;
    end
  end

  // Sequencer: next step and handshake controls.
  always_comb begin
    state_d     = state_q;
    cmd_i.ready = 1'b0;
    ram_rd_en   = 1'b0;
    load        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_i.ready = 1'b1;
        if (cmd_i.valid) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_APPLY;
      ST_APPLY: state_d = ST_READ;
      ST_READ: begin
        ram_rd_en = cvld_q;
        state_d   = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_vld_q || stat_o.ready) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= MODE_IDLE;
      before_q  <= MODE_IDLE;
      acc_q     <= '0;
      start_q   <= '0;
      split_q   <= '0;
      total_q   <= '0;
      cur_q     <= '0;
      cvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_APPLY) begin
        mode_q   <= mode_d;
        before_q <= before_d;
        acc_q    <= acc_d;
        start_q  <= start_d;
        split_q  <= split_d;
        total_q  <= total_d;
        cur_q    <= cur_d;
        cvld_q   <= cvld_d;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (stat_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: latched command, adder result, status word.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_i.valid) begin
      op_q   <= op_e'(cmd_i.op);
      time_q <= cmd_i.time_ms;
    end
    if (state_q == ST_DIFF || state_q == ST_SUM) begin
      work_q <= alu_y;
    end
    if (state_q == ST_APPLY) begin
      el_q  <= el_d;
      lap_q <= lap_ok;
    end
    if (load) begin
      stat_o.mode            <= mode_q;
      stat_o.watch_ms        <= el_q;
      stat_o.laps_stored     <= total_q;
      stat_o.lap_accepted    <= lap_q;
      stat_o.view_valid      <= cvld_q;
      stat_o.view_lap_number <= cvld_q ? (CNT_W'(cur_q) + OneCnt) : '0;
      stat_o.view_split_ms   <= cvld_q ? ram_rdata[2*TimeW-1:TimeW] : '0;
      stat_o.view_lap_ms     <= cvld_q ? ram_rdata[TimeW-1:0] : '0;
    end
  end

  assign stat_o.valid = out_vld_q;

  // Lap store; written with the split and lap duration on an accepted lap.
  lsw_ram #(
    .WIDTH (2 * TimeW),
    .DEPTH (MAX_LAPS),
    .AW    (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (state_q == ST_APPLY && lap_ok),
    .wr_addr_i (IdxW'(total_q)),
    .wr_data_i ({work_q, alu_y}),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (cur_q),
    .rd_data_o (ram_rdata)
  );

endmodule

// File: rtl/lsw_checker.sv
// Port-level checks for the lap stopwatch, attached to the top level by bind.
// Depends on lsw_pkg and the top level lap_stopwatch_with_review.
module lsw_checker #(
  parameter int unsigned MAX_LAPS = 16,
  parameter int unsigned CNT_W    = 5
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [1:0]       mode_i,
  input logic [CNT_W-1:0] laps_stored_i,
  input logic             lap_accepted_i,
  input logic             view_valid_i,
  input logic [CNT_W-1:0] view_lap_number_i,
  input logic [31:0]      view_split_ms_i,
  input logic [31:0]      view_lap_ms_i
);
  import lsw_pkg::*;

  // A stalled status word keeps its lap view.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(view_lap_number_i)
      && $stable(view_split_ms_i) && $stable(laps_stored_i))
    else $error("status word changed while stalled");

  // The lap count never exceeds the store depth.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> laps_stored_i <= CNT_W'(MAX_LAPS))
    else $error("lap count beyond store depth");

  // A recorded lap happens only while running and leaves at least one lap.
  a_lap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && lap_accepted_i |-> mode_i == MODE_RUNNING && laps_stored_i != '0)
    else $error("lap recorded outside running mode");

  // The viewed lap number lies among the stored laps, and is zero without a view.
  a_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (view_valid_i && view_lap_number_i != '0
      && view_lap_number_i <= laps_stored_i)
      || (!view_valid_i && view_lap_number_i == '0 && view_split_ms_i == '0
      && view_lap_ms_i == '0))
    else $error("lap view inconsistent with lap count");

endmodule

bind lap_stopwatch_with_review lsw_checker #(
  .MAX_LAPS (MAX_LAPS),
  .CNT_W    (CNT_W)
) u_lsw_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (stat_o.valid),
  .out_ready_i       (stat_o.ready),
  .mode_i            (stat_o.mode),
  .laps_stored_i     (stat_o.laps_stored),
  .lap_accepted_i    (stat_o.lap_accepted),
  .view_valid_i      (stat_o.view_valid),
  .view_lap_number_i (stat_o.view_lap_number),
  .view_split_ms_i   (stat_o.view_split_ms),
  .view_lap_ms_i     (stat_o.view_lap_ms)
);

// File: verif/lap_stopwatch_with_review_tb.sv
// Self-checking testbench for the lap stopwatch with lap memory and review.
// Depends on lsw_pkg, the lsw_cmd_if/lsw_stat_if channels and the block itself;
// a directed command table runs first, then random command sessions.
module lap_stopwatch_with_review_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsw_pkg::*;

  localparam int unsigned MaxLaps    = 16;
  localparam int unsigned RandCmds   = 1124;
  localparam logic [3:0]  OpUnused   = 4'hF;
  localparam int unsigned DrainLimit = 4000;
  localparam int unsigned TailCycles = 32;

  // One status word as the block reports it.
  typedef struct packed {
    mode_e       mode;
    logic [31:0] elapsed;
    logic [4:0]  laps;
    logic        lap_ok;
    logic        view_ok;
    logic [4:0]  view_num;
    logic [31:0] view_split;
    logic [31:0] view_lap;
  } status_t;

  // One row of the directed command table.
  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] stamp;
    logic        typed;
    status_t     want;
  } cmd_row_t;

  // Pending command as seen by the status predictor.
  typedef struct packed {
    logic    typed;
    status_t want;
  } pending_t;

  localparam status_t IdleZero = '{MODE_IDLE, 32'd0, 5'd0, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0};
  localparam status_t RunZero  = '{MODE_RUNNING, 32'd0, 5'd0, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0};

  logic clk_i = 1'b0;
  logic rst_ni;

  lsw_cmd_if  cmd_if ();
  lsw_stat_if #(.CNT_W(5)) stat_if ();

  lap_stopwatch_with_review i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .stat_o (stat_if)
  );

  always #1 clk_i = ~clk_i;

  // Watch state as predicted from the accepted commands.
  mode_e       watch_mode;
  mode_e       mode_before_review;
  logic [31:0] accum_ms;
  logic [31:0] start_stamp;
  logic [31:0] last_split;
  int          laps_taken;
  int          cursor;
  logic [31:0] split_mem [MaxLaps];
  logic [31:0] lap_time_mem [MaxLaps];

  status_t  status_q [$];
  pending_t pending_q [$];

  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned effective_cmds;
  int unsigned cmds_sent;
  int unsigned laps_recorded;
  int unsigned full_refusals;
  int unsigned review_entries;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  logic [31:0] wall_ms;

  cmd_row_t directed_rows [26] = '{
    '{OP_QUERY, 32'h0000_0000, 1'b1, IdleZero},
    '{OpUnused, 32'hFFFF_FFFF, 1'b1, IdleZero},
    '{OP_PAUSE, 32'h0000_0005, 1'b1, IdleZero},
    '{OP_LAP,   32'h0000_0006, 1'b1, IdleZero},
    '{OP_ENTER, 32'h0000_0007, 1'b1, IdleZero},
    '{OP_EXIT,  32'h0000_0008, 1'b1, IdleZero},
    '{OP_NEXT,  32'h0000_0009, 1'b1, IdleZero},
    '{OP_PREV,  32'h0000_000A, 1'b1, IdleZero},
    '{OP_START, 32'hFFFF_FFF0, 1'b1, RunZero},
    '{OP_START, 32'h0000_0005, 1'b0, IdleZero},
    '{OP_LAP,   32'h0000_0010, 1'b0, IdleZero},
    '{OP_LAP,   32'h0000_0100, 1'b0, IdleZero},
    '{OP_PAUSE, 32'h0000_0200, 1'b0, IdleZero},
    '{OP_PAUSE, 32'h0000_0300, 1'b0, IdleZero},
    '{OP_START, 32'h0000_1000, 1'b0, IdleZero},
    '{OP_ENTER, 32'h0000_1100, 1'b0, IdleZero},
    '{OP_START, 32'h0000_1200, 1'b0, IdleZero},
    '{OP_NEXT,  32'h0000_1300, 1'b0, IdleZero},
    '{OP_PREV,  32'h0000_1400, 1'b0, IdleZero},
    '{OP_PREV,  32'h0000_1500, 1'b0, IdleZero},
    '{OP_ENTER, 32'h0000_1600, 1'b0, IdleZero},
    '{OP_LAP,   32'h0000_1700, 1'b0, IdleZero},
    '{OP_EXIT,  32'h0000_1800, 1'b0, IdleZero},
    '{OP_QUERY, 32'hFFFF_FFFF, 1'b0, IdleZero},
    '{OP_ENTER, 32'h0000_0000, 1'b0, IdleZero},
    '{OP_RESET, 32'h0000_0001, 1'b1, IdleZero}
  };

  // Reset clears the run state; the lap store keeps its contents.
  function automatic void clear_watch();
    watch_mode         = MODE_IDLE;
    mode_before_review = MODE_IDLE;
    accum_ms           = '0;
    start_stamp        = '0;
    last_split         = '0;
    laps_taken         = 0;
    cursor             = -1;
  endfunction

  function automatic logic [31:0] elapsed_at(logic [31:0] now);
    if (watch_mode == MODE_RUNNING) begin
      return accum_ms + (now - start_stamp);
    end
    return accum_ms;
  endfunction

  // Applies one command to the predicted watch and returns the status word.
  function automatic status_t predict_status(logic [3:0] op, logic [31:0] now);
    status_t     s;
    logic [31:0] total;
    bit          acted;
    acted    = 1'b0;
    s        = IdleZero;
    case (op)
      OP_START: begin
        if (watch_mode == MODE_IDLE || watch_mode == MODE_PAUSED) begin
          start_stamp = now;
          watch_mode  = MODE_RUNNING;
          acted       = 1'b1;
        end
      end
      OP_PAUSE: begin
        if (watch_mode == MODE_RUNNING) begin
          accum_ms   = accum_ms + (now - start_stamp);
          watch_mode = MODE_PAUSED;
          acted      = 1'b1;
        end
      end
      OP_RESET: begin
        clear_watch();
        acted = 1'b1;
      end
      OP_LAP: begin
        if (watch_mode == MODE_RUNNING && laps_taken < MaxLaps) begin
          total                    = elapsed_at(now);
          split_mem[laps_taken]    = total;
          lap_time_mem[laps_taken] = total - last_split;
          last_split               = total;
          laps_taken++;
          s.lap_ok = 1'b1;
          acted    = 1'b1;
          laps_recorded++;
        end else if (watch_mode == MODE_RUNNING) begin
          full_refusals++;
        end
      end
      OP_ENTER: begin
        if (laps_taken != 0 && watch_mode != MODE_REVIEW) begin
          mode_before_review = watch_mode;
          watch_mode         = MODE_REVIEW;
          cursor             = laps_taken - 1;
          acted              = 1'b1;
          review_entries++;
        end
      end
      OP_EXIT: begin
        if (watch_mode == MODE_REVIEW) begin
          watch_mode = mode_before_review;
          acted      = 1'b1;
        end
      end
      OP_NEXT: begin
        if (watch_mode == MODE_REVIEW && cursor < laps_taken - 1) begin
          cursor++;
          acted = 1'b1;
        end
      end
      OP_PREV: begin
        if (watch_mode == MODE_REVIEW && cursor > 0) begin
          cursor--;
          acted = 1'b1;
        end
      end
      default: begin
        // Query and the unused codes only report the status.
        acted = 1'b1;
      end
    endcase
    if (acted) begin
      effective_cmds++;
    end
    s.mode    = watch_mode;
    s.elapsed = elapsed_at(now);
    s.laps    = 5'(laps_taken);
    if (cursor >= 0 && cursor < laps_taken) begin
      s.view_ok    = 1'b1;
      s.view_num   = 5'(cursor + 1);
      s.view_split = split_mem[cursor];
      s.view_lap   = lap_time_mem[cursor];
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at status word %0d: %s got %h, expected %h",
             words_checked, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Command acceptance feeds the predictor; each status word is checked in order.
  always @(posedge clk_i) begin
    status_t  want;
    pending_t pend;
    if (rst_ni) begin
      if (stat_if.valid && stat_if.ready) begin
        if (status_q.size() == 0) begin
          report_mismatch("unexpected status word", 32'd0, 32'd0);
        end else begin
          want = status_q.pop_front();
          check_field("mode", 32'(stat_if.mode), 32'(want.mode));
          check_field("watch_ms", stat_if.watch_ms, want.elapsed);
          check_field("laps_stored", 32'(stat_if.laps_stored), 32'(want.laps));
          check_field("lap_accepted", 32'(stat_if.lap_accepted), 32'(want.lap_ok));
          check_field("view_valid", 32'(stat_if.view_valid), 32'(want.view_ok));
          check_field("view_lap_number", 32'(stat_if.view_lap_number), 32'(want.view_num));
          check_field("view_split_ms", stat_if.view_split_ms, want.view_split);
          check_field("view_lap_ms", stat_if.view_lap_ms, want.view_lap);
        end
        words_checked++;
      end
      if (cmd_if.valid && cmd_if.ready) begin
        pend = pending_q.pop_front();
        want = predict_status(cmd_if.op, cmd_if.time_ms);
        status_q.push_back(pend.typed ? pend.want : want);
      end
    end
  end

  // Status channel back pressure.
  always @(negedge clk_i) begin
    stat_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Offers one command word, with random gaps, and waits for its acceptance.
  task automatic push_cmd(input logic [3:0] op, input logic [31:0] stamp,
                          input logic typed, input status_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pending_q.push_back('{typed, want});
    cmd_if.valid   <= 1'b1;
    cmd_if.op      <= op;
    cmd_if.time_ms <= stamp;
    do begin
      @(posedge clk_i);
    end while (!cmd_if.ready);
    @(negedge clk_i);
  endtask

  // Moves the wall clock on, mostly by small steps, sometimes by a jump.
  task automatic send(input logic [3:0] op);
    if ($urandom_range(99) < 5) begin
      wall_ms = $urandom();
    end else begin
      wall_ms = wall_ms + $urandom_range(0, 5000);
    end
    cmds_sent++;
    push_cmd(op, wall_ms, 1'b0, IdleZero);
  endtask

  // A typical use: start, take laps, review them, leave review; or plain noise.
  task automatic run_session();
    int laps_wanted;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 8)) send(4'($urandom_range(0, 15)));
    end else begin
      if ($urandom_range(99) < 70) begin
        send(OP_RESET);
      end
      send(OP_START);
      laps_wanted = $urandom_range(1, 20);
      repeat (laps_wanted) begin
        case ($urandom_range(0, 9))
          0: begin
            send(OP_PAUSE);
            send(OP_START);
          end
          1: send(OP_QUERY);
          2: send(4'($urandom_range(0, 15)));
          default: send(OP_LAP);
        endcase
      end
      if ($urandom_range(99) < 30) begin
        send(OP_PAUSE);
      end
      send(OP_ENTER);
      repeat ($urandom_range(0, 12)) begin
        case ($urandom_range(0, 5))
          0, 1: send(OP_NEXT);
          2, 3: send(OP_PREV);
          4: send(OP_QUERY);
          default: send(4'($urandom_range(0, 15)));
        endcase
      end
      send(OP_EXIT);
      if ($urandom_range(99) < 50) begin
        send($urandom_range(99) < 50 ? OP_LAP : OP_QUERY);
      end
    end
  endtask

  // Main stimulus: reset, directed table, random sessions, drain and verdict.
  initial begin
    int unsigned waited;
    rst_ni         = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.op      = OP_QUERY;
    cmd_if.time_ms = '0;
    stat_if.ready  = 1'b0;
    src_idle_pct   = 20;
    snk_idle_pct   = 48;
    mismatches     = 0;
    words_checked  = 0;
    effective_cmds = 0;
    cmds_sent      = 0;
    laps_recorded  = 0;
    full_refusals  = 0;
    review_entries = 0;
    wall_ms        = $urandom();
    clear_watch();
    for (int i = 0; i < MaxLaps; i++) begin
      split_mem[i]    = '0;
      lap_time_mem[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      push_cmd(directed_rows[i].op, directed_rows[i].stamp,
               directed_rows[i].typed, directed_rows[i].want);
    end

    // Random sessions in three idling phases: sender light, receiver light, none.
    while (cmds_sent < RandCmds) begin
      if (cmds_sent < RandCmds / 3) begin
        src_idle_pct = 20;
        snk_idle_pct = 48;
      end else if (cmds_sent < 2 * RandCmds / 3) begin
        src_idle_pct = 48;
        snk_idle_pct = 20;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      run_session();
    end
    cmd_if.valid <= 1'b0;

    waited = 0;
    while (status_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (status_q.size() != 0) begin
      report_mismatch("status words never delivered", 32'(status_q.size()), 32'd0);
    end
    repeat (TailCycles) @(posedge clk_i);

    $display("run covered %0d status words, %0d commands that acted, %0d laps recorded,",
             words_checked, effective_cmds, laps_recorded);
    $display("%0d laps refused on a full store, %0d review entries and %0d mismatches",
             full_refusals, review_entries, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
